// File: rtl/hiq_pkg.sv
// ----------------------------------------------------------------------------
// hiq_pkg
// Shared types and constants of the histogram equalizer: action codes,
// counter widths, the memory request and the shared arithmetic unit request.
// ----------------------------------------------------------------------------
package hiq_pkg;

	// histogram geometry
	localparam int NUM_BINS = 256;
	localparam int BIN_AW   = 8;
	localparam int CNT_W    = 21;
	localparam int CDF_W    = 29;
	localparam int ALU_W    = 38;
	localparam int DSH_W    = 29;
	localparam int STEP_W   = 3;

	// counter saturation level
	localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);

	// clamp level of the equalized output
	localparam logic [7:0] TOP_LEVEL = 8'd255;

	// last quotient bit step of the divider
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(7);

	// action codes of an input beat
	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_COUNT = 2'd1,
		ACT_MAP   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// shared unit operations
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             borrow;
	} alu_rsp_t;

	// bin memory request
	typedef struct packed {
		logic              clr;
		logic              rd;
		logic              wr;
		logic [BIN_AW-1:0] addr;
		logic [CNT_W-1:0]  wdata;
	} mem_req_t;

endpackage

// File: rtl/hiq_bin_mem.sv
// ----------------------------------------------------------------------------
// hiq_bin_mem
// 256-entry bin count memory with one valid bit per entry. A clear drops all
// valid bits at once; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module hiq_bin_mem
	import hiq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mem_req_t         req,
	output logic [CNT_W-1:0] rdata
);

	logic [CNT_W-1:0]    mem_q [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [CNT_W-1:0]    rd_q;
	logic                rd_vld_q;

	// storage write
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem_q[req.addr] <= req.wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_q <= mem_q[req.addr];
		end
	end

	// valid bits, cleared by reset or a clear beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/hiq_alu.sv
// ----------------------------------------------------------------------------
// hiq_alu
// Shared add / subtract unit. Serves the bin increment, the cdf sum, the
// x510 scaling, the rounding add and each compare-and-subtract of the divider.
// ----------------------------------------------------------------------------
module hiq_alu
	import hiq_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W:0] sum;

	// one wide adder, borrow taken from the extra top bit
	always_comb begin
		unique case (req.op)
			ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
			default: sum = '0;
		endcase
	end

	assign rsp.res    = sum[ALU_W-1:0];
	assign rsp.borrow = (req.op == ALU_SUB) && sum[ALU_W];

endmodule

// File: rtl/hiq_ctrl.sv
// ----------------------------------------------------------------------------
// hiq_ctrl
// Sequencer of the equalizer. Takes input beats, keeps the pixel total,
// walks the bins for the cdf, scales and divides with the shared unit and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
module hiq_ctrl
	import hiq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  logic [1:0]       action,
	input  logic [7:0]       pixel_value,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [7:0]       equalized_value,
	output mem_req_t         mem_req,
	input  logic [CNT_W-1:0] mem_rdata,
	output alu_req_t         alu_req,
	input  alu_rsp_t         alu_rsp
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CNT  = 8'b0000_0010,
		ST_SUM  = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_ADD  = 8'b0001_0000,
		ST_OVF  = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [7:0]         pix_q;
	logic [CNT_W-1:0]   total_q;
	logic [BIN_AW:0]    iss_q;
	logic               pend_q;
	logic [CDF_W-1:0]   acc_q;
	logic [ALU_W-1:0]   num_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [7:0]         quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_vld_q;
	logic [7:0]         out_val_q;

	logic               accept;
	action_t            act;
	logic               issue;
	logic [CNT_W:0]     den2;
	logic               out_free;

	assign accept    = pix_valid && (state_q == ST_IDLE);
	assign act       = action_t'(action);
	assign pix_stall = (state_q != ST_IDLE);
	assign den2      = {total_q, 1'b0};
	assign out_free  = !out_vld_q || !res_stall;

	// next bin read of the cdf walk
	assign issue = (state_q == ST_SUM) && !iss_q[BIN_AW] && (iss_q[BIN_AW-1:0] <= pix_q);

	// bin memory requests
	always_comb begin
		mem_req       = '0;
		mem_req.clr   = accept && (act == ACT_CLEAR);
		mem_req.addr  = pixel_value;
		mem_req.wdata = alu_rsp.res[CNT_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				mem_req.rd = accept && (act == ACT_COUNT);
			end
			ST_CNT: begin
				mem_req.addr = pix_q;
				mem_req.wr   = (mem_rdata < MAX_PIXELS);
			end
			ST_SUM: begin
				mem_req.addr = iss_q[BIN_AW-1:0];
				mem_req.rd   = issue;
			end
			default: begin
				mem_req.addr = pix_q;
			end
		endcase
	end

	// operand selection of the shared unit
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		unique case (state_q)
			ST_CNT: begin
				alu_req.a = ALU_W'(mem_rdata);
				alu_req.b = ALU_W'(1);
			end
			ST_SUM: begin
				alu_req.a = ALU_W'(acc_q);
				alu_req.b = ALU_W'(mem_rdata);
			end
			ST_MUL: begin
				// 510 * cdf as (cdf << 9) - (cdf << 1)
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'({acc_q, 9'b0});
				alu_req.b  = ALU_W'({acc_q, 1'b0});
			end
			ST_ADD: begin
				alu_req.a = num_q;
				alu_req.b = ALU_W'(total_q);
			end
			ST_OVF: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = num_q;
				alu_req.b  = ALU_W'({den2, 8'b0});
			end
			ST_DIV: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = num_q;
				alu_req.b  = ALU_W'(dsh_q);
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			iss_q     <= '0;
			pend_q    <= 1'b0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// result beat taken, unless a new one replaces it this cycle
			if (out_vld_q && !res_stall && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pix_q <= pixel_value;
						unique case (act)
							ACT_CLEAR: total_q <= '0;
							ACT_COUNT: begin
								if (total_q < MAX_PIXELS) begin
									total_q <= total_q + CNT_W'(1);
								end
								state_q <= ST_CNT;
							end
							ACT_MAP: begin
								acc_q  <= '0;
								iss_q  <= '0;
								pend_q <= 1'b0;
								quo_q  <= '0;
								if (total_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SUM;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CNT: begin
					state_q <= ST_IDLE;
				end
				ST_SUM: begin
					if (pend_q) begin
						acc_q <= alu_rsp.res[CDF_W-1:0];
					end
					pend_q <= issue;
					iss_q  <= iss_q + (BIN_AW+1)'(issue);
					if (!issue && !pend_q) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					num_q   <= alu_rsp.res;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					num_q   <= alu_rsp.res;
					state_q <= ST_OVF;
				end
				ST_OVF: begin
					if (!alu_rsp.borrow) begin
						quo_q   <= TOP_LEVEL;
						state_q <= ST_DONE;
					end else begin
						dsh_q   <= DSH_W'({den2, 7'b0});
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring step: one quotient bit a cycle
					if (!alu_rsp.borrow) begin
						num_q <= alu_rsp.res;
					end
					quo_q  <= {quo_q[6:0], !alu_rsp.borrow};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_val_q <= quo_q;
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid       = out_vld_q;
	assign equalized_value = out_val_q;

endmodule

// File: rtl/histogram_equalizer.sv
// ----------------------------------------------------------------------------
// histogram_equalizer
// 8-bit grayscale histogram equalization over a 256-bin histogram.
// ----------------------------------------------------------------------------
// The block takes one beat at a time and stalls its input until that beat is
// done. A clear beat (action 0) empties the histogram and the pixel total. A
// count beat (action 1) reads the bin and writes it back, saturating. A map
// beat (action 2) walks bins 0..pixel_value through the single read port of
// the bin memory, one bin a cycle, then scales by 510 and divides by twice
// the pixel total with the shared add/subtract unit, one quotient bit a
// cycle. Only map beats give a result, rounded half up and clamped to 255;
// with an empty histogram the result is 0. Bins and the total stop at
// 1048576 pixels.
// ----------------------------------------------------------------------------
module histogram_equalizer
	import hiq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_stall,
	input  logic [1:0] action,
	input  logic [7:0] pixel_value,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] equalized_value
);

	mem_req_t         mem_req;
	logic [CNT_W-1:0] mem_rdata;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	// bin storage
	hiq_bin_mem u_bin_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	// shared arithmetic unit
	hiq_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// sequencer
	hiq_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_valid       (pix_valid),
		.pix_stall       (pix_stall),
		.action          (action),
		.pixel_value     (pixel_value),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.equalized_value (equalized_value),
		.mem_req         (mem_req),
		.mem_rdata       (mem_rdata),
		.alu_req         (alu_req),
		.alu_rsp         (alu_rsp)
	);

endmodule

// File: sim/tb_histogram_equalizer.sv
// ----------------------------------------------------------------------------
// tb_histogram_equalizer
// Self-checking bench for the histogram equalizer. A queue of pixel beats
// (directed corner cases, then random clear/count/map runs with some noise)
// feeds a falling-edge driver. A rising-edge monitor keeps its own copy of
// the histogram, predicts every equalized level and checks each result beat
// in order. Sender gaps and result back-pressure change in three phases.
// ----------------------------------------------------------------------------
module tb_histogram_equalizer;
	import hiq_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 300;

	typedef struct {
		action_t    act;
		logic [7:0] level;
		int         phase;
		bit         hold;
	} pix_item_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       pix_valid   = 1'b0;
	logic       pix_stall;
	logic [1:0] action      = ACT_NONE;
	logic [7:0] pixel_value = 8'd0;
	logic       res_valid;
	logic       res_stall   = 1'b0;
	logic [7:0] equalized_value;

	// stimulus queue and driver state
	pix_item_t   pix_queue[$];
	pix_item_t   head;
	logic        pix_taken   = 1'b0;
	int          drive_phase = 0;
	int          gen_phase   = 0;
	int unsigned send_idle_pct[3] = '{8, 48, 0};
	int unsigned res_stall_pct[3] = '{48, 8, 0};

	// predicted histogram and pending equalized levels
	logic [CNT_W-1:0] hist_bins [NUM_BINS];
	logic [CNT_W-1:0] hist_total;
	logic [7:0]       equalized_due[$];
	logic [7:0]       due_level;

	int unsigned cycle_count = 0;
	int unsigned errors      = 0;

	histogram_equalizer u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_valid       (pix_valid),
		.pix_stall       (pix_stall),
		.action          (action),
		.pixel_value     (pixel_value),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.equalized_value (equalized_value)
	);

	always #5 clk = ~clk;

	// round(255 * cdf / total), half up, clamped; empty histogram gives 0
	function automatic logic [7:0] predict_equalized(input logic [7:0] level);
		logic [63:0] cdf;
		logic [63:0] den;
		logic [63:0] q;
		cdf = 64'd0;
		if (hist_total == '0)
			return 8'd0;
		for (int k = 0; k <= int'(level); k++)
			cdf += 64'(hist_bins[k]);
		den = 64'(hist_total);
		q   = (2 * 64'(TOP_LEVEL) * cdf + den) / (2 * den);
		if (q > 64'(TOP_LEVEL))
			q = 64'(TOP_LEVEL);
		return q[7:0];
	endfunction

	task automatic clear_hist();
		for (int k = 0; k < NUM_BINS; k++)
			hist_bins[k] = '0;
		hist_total = '0;
	endtask

	task automatic add_item(input action_t act, input logic [7:0] level, input bit hold);
		pix_item_t it;
		it.act   = act;
		it.level = level;
		it.phase = gen_phase;
		it.hold  = hold;
		pix_queue.push_back(it);
	endtask

	initial clear_hist();

	// driver: new beat at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix_valid || pix_taken) begin
				if (pix_queue.size() == 0
						|| (pix_queue[0].hold && equalized_due.size() != 0)
						|| $urandom_range(99) < send_idle_pct[pix_queue[0].phase]) begin
					pix_valid <= 1'b0;
				end else begin
					head = pix_queue.pop_front();
					pix_valid   <= 1'b1;
					action      <= head.act;
					pixel_value <= head.level;
					drive_phase <= head.phase;
				end
			end
			// result back-pressure
			res_stall <= ($urandom_range(99) < res_stall_pct[drive_phase]);
		end
	end

	// monitor: predict on accepted pixel beats, check result beats
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			pix_taken   <= pix_valid && !pix_stall;
			if (res_valid && !res_stall) begin
				if (equalized_due.size() == 0) begin
					$display("%0t: unexpected result beat, equalized_value %0d",
						$time, equalized_value);
					errors++;
				end else begin
					due_level = equalized_due.pop_front();
					if (equalized_value !== due_level) begin
						$display("%0t: equalized_value mismatch: expected %0d, actual %0d",
							$time, due_level, equalized_value);
						errors++;
					end
				end
			end
			if (pix_valid && !pix_stall) begin
				case (action_t'(action))
					ACT_CLEAR: begin
						clear_hist();
					end
					ACT_COUNT: begin
						if (hist_bins[pixel_value] < MAX_PIXELS)
							hist_bins[pixel_value] = hist_bins[pixel_value] + CNT_W'(1);
						if (hist_total < MAX_PIXELS)
							hist_total = hist_total + CNT_W'(1);
					end
					ACT_MAP: begin
						equalized_due.push_back(predict_equalized(pixel_value));
					end
					default: begin
					end
				endcase
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int unsigned n_random;
		int          prev_phase;
		int unsigned n_counts;
		int unsigned n_maps;
		int unsigned kind;
		logic [7:0]  center;
		logic [7:0]  lvl;
		action_t     act;

		// directed: empty histogram, unused code, extremes, rounding
		add_item(ACT_MAP, 8'd0, 1'b0);
		add_item(ACT_MAP, 8'd255, 1'b0);
		add_item(ACT_NONE, 8'hAA, 1'b0);
		add_item(ACT_COUNT, 8'd0, 1'b0);
		add_item(ACT_COUNT, 8'd255, 1'b0);
		add_item(ACT_MAP, 8'd0, 1'b0);
		add_item(ACT_MAP, 8'd255, 1'b0);
		add_item(ACT_COUNT, 8'd255, 1'b0);
		add_item(ACT_COUNT, 8'd255, 1'b0);
		add_item(ACT_MAP, 8'd128, 1'b0);
		add_item(ACT_NONE, 8'h55, 1'b0);
		add_item(ACT_CLEAR, 8'hFF, 1'b0);
		add_item(ACT_MAP, 8'd200, 1'b0);
		add_item(ACT_COUNT, 8'd128, 1'b0);
		add_item(ACT_MAP, 8'd127, 1'b0);
		add_item(ACT_MAP, 8'd128, 1'b0);
		add_item(ACT_CLEAR, 8'd0, 1'b0);
		add_item(ACT_COUNT, 8'd10, 1'b0);
		add_item(ACT_COUNT, 8'd20, 1'b0);
		add_item(ACT_MAP, 8'd10, 1'b0);
		add_item(ACT_MAP, 8'd9, 1'b0);
		add_item(ACT_MAP, 8'd255, 1'b0);

		// random: mostly clear / count run / map run, some noise
		n_random   = 0;
		prev_phase = 0;
		while (n_random < RANDOM_ITEMS) begin
			gen_phase = int'(n_random * 3 / RANDOM_ITEMS);
			kind      = $urandom_range(99);
			center    = 8'($urandom_range(255));
			if (kind < 80) begin
				// whole image: clear, count pass, map pass
				add_item(ACT_CLEAR, 8'($urandom_range(255)),
					gen_phase != prev_phase || $urandom_range(19) == 0);
				n_counts = $urandom_range(1, 40);
				n_maps   = $urandom_range(1, 12);
				n_random += 1 + n_counts + n_maps;
				repeat (n_counts) begin
					lvl = $urandom_range(1) ? 8'($urandom_range(255))
						: center + 8'($urandom_range(15));
					add_item(ACT_COUNT, lvl, 1'b0);
				end
				repeat (n_maps) begin
					act = ($urandom_range(99) < 15) ? ACT_COUNT : ACT_MAP;
					lvl = $urandom_range(1) ? 8'($urandom_range(255))
						: center + 8'($urandom_range(15));
					add_item(act, lvl, 1'b0);
				end
			end else if (kind < 90) begin
				// maps on an empty histogram
				add_item(ACT_CLEAR, 8'($urandom_range(255)), 1'b0);
				n_maps = $urandom_range(1, 4);
				n_random += 1 + n_maps;
				repeat (n_maps)
					add_item(ACT_MAP, 8'($urandom_range(255)), 1'b0);
			end else begin
				// noise, unused code included
				repeat ($urandom_range(1, 6)) begin
					act = action_t'($urandom_range(3));
					add_item(act, 8'($urandom_range(255)), 1'b0);
					if (act != ACT_NONE)
						n_random++;
				end
			end
			prev_phase = gen_phase;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain
		while (pix_queue.size() != 0 || pix_valid)
			@(posedge clk);
		while (equalized_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && equalized_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: histogram_equalizer.f
rtl/hiq_pkg.sv
rtl/hiq_bin_mem.sv
rtl/hiq_alu.sv
rtl/hiq_ctrl.sv
rtl/histogram_equalizer.sv
sim/tb_histogram_equalizer.sv
